// ===== hdl/self_calibrating_subminute_millis_macros.svh =====
`ifndef SELF_CALIBRATING_SUBMINUTE_MILLIS_MACROS_SVH
`define SELF_CALIBRATING_SUBMINUTE_MILLIS_MACROS_SVH

// check cons in the same cycle as ante
`define SCSM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scsm assertion failed");

// check cons in the cycle after ante
`define SCSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scsm assertion failed");

`endif

// ===== hdl/scsm_pkg.sv =====
`default_nettype none

package scsm_pkg;

    localparam int unsigned FIELD_W    = 7;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned EST_W      = 32;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned INC_W      = 16;
    localparam int unsigned GAIN_SHIFT = 6;
    localparam int unsigned PROD_W     = INC_W + GAIN_SHIFT;
    localparam int unsigned MS_W       = 17;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd24;
    localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
    localparam logic [FIELD_W-1:0] SECOND_MAX = 7'd59;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd282;
    localparam logic [GAIN_W-1:0]  GAIN_TOP   = 16'hFFFF;
    localparam logic [MS_W-1:0]    MS_PER_SEC = 17'd1000;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 72;

    typedef struct packed {
        logic                kind;
        logic [FIELD_W-1:0]  rtc_hour;
        logic [FIELD_W-1:0]  rtc_minute;
        logic [FIELD_W-1:0]  rtc_second;
        logic [STAMP_W-1:0]  now_ms;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  hour_out;
        logic [FIELD_W-1:0]  minute_out;
        logic [FIELD_W-1:0]  second_out;
        logic                hour_clamped;
        logic                minute_clamped;
        logic                second_clamped;
        logic [EST_W-1:0]    ms_estimate;
        logic [GAIN_W-1:0]   gain_out;
    } result_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  last_minute;
        logic [FIELD_W-1:0]  last_second;
        logic [STAMP_W-1:0]  last_stamp;
        logic [EST_W-1:0]    estimate;
        logic [GAIN_W-1:0]   gain;
    } state_t;

    function automatic logic [MS_W-1:0] sec_to_ms(input logic [FIELD_W-1:0] sec);
        sec_to_ms = MS_W'({10'd0, sec} * MS_PER_SEC);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scsm_calc.sv =====
`default_nettype none

module scsm_calc (
    input  scsm_pkg::item_t   item,
    input  scsm_pkg::state_t  state,
    output scsm_pkg::state_t  state_next,
    output scsm_pkg::result_t result
);

    logic [scsm_pkg::FIELD_W-1:0] hour_c;
    logic [scsm_pkg::FIELD_W-1:0] minute_c;
    logic [scsm_pkg::FIELD_W-1:0] second_c;
    logic                         hour_hi;
    logic                         minute_hi;
    logic                         second_hi;
    logic                         minute_chg;
    logic                         second_chg;
    logic [scsm_pkg::EST_W-1:0]   base_est;
    logic [scsm_pkg::STAMP_W-1:0] base_stamp;
    logic [scsm_pkg::STAMP_W-1:0] elapsed;
    logic [scsm_pkg::PROD_W-1:0]  prod;
    logic [scsm_pkg::INC_W-1:0]   inc;
    logic [scsm_pkg::EST_W-1:0]   est_sum;
    logic [scsm_pkg::MS_W-1:0]    target_ms;
    logic [scsm_pkg::MS_W-1:0]    raw_ms;
    logic                         ahead;
    logic [scsm_pkg::GAIN_W-1:0]  gain_adj;

    always_comb begin
        hour_hi   = item.rtc_hour > scsm_pkg::HOUR_MAX;
        minute_hi = item.rtc_minute > scsm_pkg::MINUTE_MAX;
        second_hi = item.rtc_second > scsm_pkg::SECOND_MAX;
        hour_c    = hour_hi ? scsm_pkg::HOUR_MAX : item.rtc_hour;
        minute_c  = minute_hi ? '0 : item.rtc_minute;
        second_c  = second_hi ? scsm_pkg::SECOND_MAX : item.rtc_second;

        target_ms = scsm_pkg::sec_to_ms(second_c);
        raw_ms    = scsm_pkg::sec_to_ms(item.rtc_second);

        minute_chg = minute_c != state.last_minute;
        second_chg = second_c != state.last_second;
        base_est   = minute_chg ? {{(scsm_pkg::EST_W-scsm_pkg::MS_W){1'b0}}, target_ms}
                                : state.estimate;
        base_stamp = minute_chg ? item.now_ms : state.last_stamp;

        elapsed = item.now_ms - base_stamp;
        prod    = elapsed[scsm_pkg::PROD_W-1:0]
                * {{(scsm_pkg::PROD_W-scsm_pkg::GAIN_W){1'b0}}, state.gain};
        inc     = prod[scsm_pkg::PROD_W-1:scsm_pkg::GAIN_SHIFT];
        est_sum = base_est + {{(scsm_pkg::EST_W-scsm_pkg::INC_W){1'b0}}, inc};

        ahead = $signed(est_sum)
              > $signed({{(scsm_pkg::EST_W-scsm_pkg::MS_W){1'b0}}, target_ms});
        gain_adj = state.gain;
        if (second_chg) begin
            if (ahead) begin
                if (state.gain != '0) begin
                    gain_adj = state.gain - 1'b1;
                end
            end else if (state.gain != scsm_pkg::GAIN_TOP) begin
                gain_adj = state.gain + 1'b1;
            end
        end

        state_next = state;
        result     = '0;
        case (item.kind)
            scsm_pkg::KIND_START: begin
                state_next.last_stamp = item.now_ms;
                state_next.estimate   = {{(scsm_pkg::EST_W-scsm_pkg::MS_W){1'b0}}, raw_ms};
                result.hour_out       = item.rtc_hour;
                result.minute_out     = item.rtc_minute;
                result.second_out     = item.rtc_second;
            end
            scsm_pkg::KIND_POLL: begin
                state_next.last_minute = minute_c;
                state_next.last_second = second_c;
                state_next.last_stamp  = item.now_ms;
                state_next.estimate    = est_sum;
                state_next.gain        = gain_adj;
                result.hour_out        = hour_c;
                result.minute_out      = minute_c;
                result.second_out      = second_c;
                result.hour_clamped    = hour_hi;
                result.minute_clamped  = minute_hi;
                result.second_clamped  = second_hi;
            end
            default: begin
                state_next = state;
            end
        endcase
        result.ms_estimate = state_next.estimate;
        result.gain_out    = state_next.gain;
    end

endmodule

`default_nettype wire

// ===== hdl/self_calibrating_subminute_millis.sv =====
// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tuser kind, s_tdata clock readings and timestamp
// m_        out        m_tvalid/m_tready  m_tdata readings, clamp flags, estimate, gain
// cfg_      in         cfg_we             cfg_wdata initial gain, reloads gain
//
// One beat per cycle unless m_ stalls; the input register feeds the result register.
// The path from the input register through the 22x16 multiply, the estimate add
// and the signed compare to the result register sets the clock period.
// aresetn clears both pipeline valids, the estimator state and reloads gain to 282.
// A stalled m_ side holds the result register and backs up into the input register.
`default_nettype none

`include "self_calibrating_subminute_millis_macros.svh"

module self_calibrating_subminute_millis (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // rtc_hour[6:0], rtc_minute[13:7], rtc_second[20:14], now_ms[52:21]
    input  wire logic [scsm_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // hour_out[6:0], minute_out[13:7], second_out[20:14], hour_clamped[21],
    // minute_clamped[22], second_clamped[23], ms_estimate[55:24], gain_out[71:56]
    output logic [scsm_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [scsm_pkg::GAIN_W-1:0]      cfg_wdata
);

    logic              in_valid_reg;
    scsm_pkg::item_t   in_reg;
    logic              out_valid_reg;
    scsm_pkg::result_t out_reg;
    scsm_pkg::state_t  state_reg;
    scsm_pkg::state_t  state_next;
    scsm_pkg::result_t result_next;
    scsm_pkg::item_t   s_item;
    logic              advance;
    logic              in_go;

    assign advance  = !out_valid_reg || m_tready;
    assign in_go    = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign s_item.kind       = s_tuser;
    assign s_item.rtc_hour   = s_tdata[6:0];
    assign s_item.rtc_minute = s_tdata[13:7];
    assign s_item.rtc_second = s_tdata[20:14];
    assign s_item.now_ms     = s_tdata[52:21];

    scsm_calc u_calc (
        .item       (in_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{last_minute: '0, last_second: '0, last_stamp: '0,
                               estimate: '0, gain: scsm_pkg::GAIN_RESET};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we) begin
                state_reg.gain <= cfg_wdata;
            end else if (in_go) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_item;
        end
        if (in_go) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.gain_out, out_reg.ms_estimate, out_reg.second_clamped,
                       out_reg.minute_clamped, out_reg.hour_clamped, out_reg.second_out,
                       out_reg.minute_out, out_reg.hour_out};

    `SCSM_ASSERT_NEXT(a_beat_gives_result, aclk, aresetn, in_go, m_tvalid)
    `SCSM_ASSERT_NEXT(a_gain_holds, aclk, aresetn, !in_go && !cfg_we, $stable(state_reg.gain))
    `SCSM_ASSERT_SAME(a_minute_in_range, aclk, aresetn, 1'b1,
                      state_reg.last_minute <= scsm_pkg::MINUTE_MAX)
    `SCSM_ASSERT_SAME(a_minute_clamp_zero, aclk, aresetn, m_tvalid && out_reg.minute_clamped,
                      out_reg.minute_out == '0)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scsm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 255;
    localparam int LONG_HOLD   = 90;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we   = 1'b0;
    logic [GAIN_W-1:0]    cfg_wdata = '0;

    result_t  exp_results[$];
    dir_row_t dir_rows[$];
    int       err_cnt   = 0;
    int       cycles    = 0;
    int       phase_no  = -1;
    int       tx_idle_pct = 36;
    int       rx_idle_pct = 74;
    int       hold_left = 0;
    bit       long_hold_done = 1'b0;

    // predictor state
    logic [FIELD_W-1:0] est_last_minute;
    logic [FIELD_W-1:0] est_last_second;
    logic [STAMP_W-1:0] est_last_stamp;
    logic [EST_W-1:0]   est_value;
    logic [GAIN_W-1:0]  est_gain;

    // wall clock behind the well-formed stimulus
    int          clk_h = 0;
    int          clk_m = 0;
    int          clk_s = 0;
    int          clk_sub = 0;
    logic [31:0] clk_now = 32'd0;

    self_calibrating_subminute_millis u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic result_t mk_result(
        input logic [FIELD_W-1:0] h, input logic [FIELD_W-1:0] m,
        input logic [FIELD_W-1:0] s, input logic hc, input logic mc, input logic sc,
        input logic [EST_W-1:0] est, input logic [GAIN_W-1:0] g);
        result_t r;
        r.hour_out       = h;
        r.minute_out     = m;
        r.second_out     = s;
        r.hour_clamped   = hc;
        r.minute_clamped = mc;
        r.second_clamped = sc;
        r.ms_estimate    = est;
        r.gain_out       = g;
        return r;
    endfunction

    task automatic estimate_item(input item_t it, output result_t r);
        logic [FIELD_W-1:0] h, m, s;
        logic               hc, mc, sc;
        logic [31:0]        elapsed, prod, sec_ms;
        logic [INC_W-1:0]   inc;
        h  = it.rtc_hour;
        m  = it.rtc_minute;
        s  = it.rtc_second;
        hc = 1'b0;
        mc = 1'b0;
        sc = 1'b0;
        if (it.kind == KIND_START) begin
            est_last_stamp = it.now_ms;
            est_value      = {25'd0, s} * 32'(MS_PER_SEC);
        end else begin
            if (h > HOUR_MAX) begin
                h  = HOUR_MAX;
                hc = 1'b1;
            end
            if (m > MINUTE_MAX) begin
                m  = '0;
                mc = 1'b1;
            end
            if (s > SECOND_MAX) begin
                s  = SECOND_MAX;
                sc = 1'b1;
            end
            if (m != est_last_minute) begin
                est_last_minute = m;
                est_last_stamp  = it.now_ms;
                est_value       = {25'd0, s} * 32'(MS_PER_SEC);
            end
            elapsed        = it.now_ms - est_last_stamp;
            est_last_stamp = it.now_ms;
            prod           = elapsed * {16'd0, est_gain};
            inc            = prod[INC_W+GAIN_SHIFT-1:GAIN_SHIFT];
            est_value      = est_value + {16'd0, inc};
            if (s != est_last_second) begin
                est_last_second = s;
                sec_ms = {25'd0, s} * 32'(MS_PER_SEC);
                if ($signed(est_value) > $signed(sec_ms)) begin
                    if (est_gain != '0) est_gain = est_gain - 1'b1;
                end else begin
                    if (est_gain != GAIN_TOP) est_gain = est_gain + 1'b1;
                end
            end
        end
        r = mk_result(h, m, s, hc, mc, sc, est_value, est_gain);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic add_row(input logic k, input logic [6:0] h, input logic [6:0] m,
                           input logic [6:0] s, input logic [31:0] now,
                           input bit typed, input result_t want);
        dir_row_t row;
        row.stim.kind       = k;
        row.stim.rtc_hour   = h;
        row.stim.rtc_minute = m;
        row.stim.rtc_second = s;
        row.stim.now_ms     = now;
        row.typed           = typed;
        row.want            = want;
        dir_rows.push_back(row);
    endtask

    // present one beat, hold until accepted, queue its expected result
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.now_ms, it.rtc_second, it.rtc_minute, it.rtc_hour};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        estimate_item(it, r);
        if (typed) r = want;
        exp_results.push_back(r);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (exp_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        est_gain   = v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // push the gain once down and once up from wherever it sits
    task automatic sat_probe();
        item_t it;
        logic [6:0] sec_next;
        it.rtc_hour   = 7'(clk_h);
        it.rtc_minute = est_last_minute;
        it.now_ms     = clk_now;
        it.kind       = KIND_START;
        it.rtc_second = 7'd127;
        send_item(it, 1'b0, '0);
        sec_next      = 7'((est_last_second + 1) % 60);
        it.kind       = KIND_POLL;
        it.rtc_second = sec_next;
        send_item(it, 1'b0, '0);
        it.kind       = KIND_START;
        it.rtc_second = 7'd0;
        send_item(it, 1'b0, '0);
        it.kind       = KIND_POLL;
        it.rtc_second = 7'((sec_next + 1) % 60);
        send_item(it, 1'b0, '0);
    endtask

    task automatic next_random_item(output item_t it);
        int roll;
        int adv;
        roll = $urandom_range(99);
        if (roll < 15) begin
            it.kind       = 1'($urandom_range(1));
            it.rtc_hour   = 7'($urandom);
            it.rtc_minute = 7'($urandom);
            it.rtc_second = 7'($urandom);
            it.now_ms     = $urandom;
        end else begin
            if ($urandom_range(99) < 2) begin
                clk_now = clk_now + $urandom;
            end else begin
                adv     = $urandom_range(450);
                clk_now = clk_now + 32'(adv);
                clk_sub = clk_sub + adv;
            end
            while (clk_sub >= 1000) begin
                clk_sub -= 1000;
                clk_s++;
                if (clk_s == 60) begin
                    clk_s = 0;
                    clk_m++;
                    if (clk_m == 60) begin
                        clk_m = 0;
                        clk_h = (clk_h + 1) % 24;
                    end
                end
            end
            it.kind       = (roll < 19) ? KIND_START : KIND_POLL;
            it.rtc_hour   = 7'(clk_h);
            it.rtc_minute = 7'(clk_m);
            it.rtc_second = 7'(clk_s);
            it.now_ms     = clk_now;
        end
    endtask

    always @(negedge aclk) begin
        if (phase_no == 1 && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hour_out       = m_tdata[6:0];
            got.minute_out     = m_tdata[13:7];
            got.second_out     = m_tdata[20:14];
            got.hour_clamped   = m_tdata[21];
            got.minute_clamped = m_tdata[22];
            got.second_clamped = m_tdata[23];
            got.ms_estimate    = m_tdata[55:24];
            got.gain_out       = m_tdata[71:56];
            if (exp_results.size() == 0) begin
                report_mismatch("beat with nothing queued", 0, 0);
            end else begin
                want = exp_results.pop_front();
                if (got.hour_out != want.hour_out)
                    report_mismatch("hour_out", got.hour_out, want.hour_out);
                if (got.minute_out != want.minute_out)
                    report_mismatch("minute_out", got.minute_out, want.minute_out);
                if (got.second_out != want.second_out)
                    report_mismatch("second_out", got.second_out, want.second_out);
                if (got.hour_clamped != want.hour_clamped)
                    report_mismatch("hour_clamped", got.hour_clamped, want.hour_clamped);
                if (got.minute_clamped != want.minute_clamped)
                    report_mismatch("minute_clamped", got.minute_clamped,
                                    want.minute_clamped);
                if (got.second_clamped != want.second_clamped)
                    report_mismatch("second_clamped", got.second_clamped,
                                    want.second_clamped);
                if (got.ms_estimate != want.ms_estimate)
                    report_mismatch("ms_estimate", longint'($signed(got.ms_estimate)),
                                    longint'($signed(want.ms_estimate)));
                if (got.gain_out != want.gain_out)
                    report_mismatch("gain_out", got.gain_out, want.gain_out);
            end
        end
    end

    initial begin
        logic [GAIN_W-1:0] gain_set [PHASES];
        item_t             it;
        est_last_minute = '0;
        est_last_second = '0;
        est_last_stamp  = '0;
        est_value       = '0;
        est_gain        = GAIN_RESET;

        gain_set[0] = '0;
        gain_set[1] = GAIN_TOP;
        gain_set[2] = 16'($urandom);
        gain_set[3] = 16'd1;
        gain_set[4] = GAIN_TOP - 1'b1;
        gain_set[5] = 16'($urandom_range(400, 2));

        add_row(KIND_START, 7'd0, 7'd0, 7'd0, 32'h0000_0000, 1'b1,
                mk_result(7'd0, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 32'd0, 16'd282));
        add_row(KIND_START, 7'd127, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1,
                mk_result(7'd127, 7'd127, 7'd127, 1'b0, 1'b0, 1'b0, 32'd127000, 16'd282));
        add_row(KIND_POLL, 7'd127, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1,
                mk_result(7'd24, 7'd0, 7'd59, 1'b1, 1'b1, 1'b1, 32'd127000, 16'd281));
        add_row(KIND_POLL, 7'd25, 7'd60, 7'd60, 32'hFFFF_FFFF, 1'b1,
                mk_result(7'd24, 7'd0, 7'd59, 1'b1, 1'b1, 1'b1, 32'd127000, 16'd281));
        add_row(KIND_POLL, 7'd24, 7'd59, 7'd59, 32'hFFFF_FFFF, 1'b1,
                mk_result(7'd24, 7'd59, 7'd59, 1'b0, 1'b0, 1'b0, 32'd59000, 16'd281));
        add_row(KIND_POLL, 7'd0, 7'd59, 7'd59, 32'h0000_03E7, 1'b0, '0);
        add_row(KIND_POLL, 7'd23, 7'd59, 7'd0, 32'h0000_07CF, 1'b0, '0);
        add_row(KIND_POLL, 7'd12, 7'd59, 7'd1, 32'h0000_0BB7, 1'b0, '0);
        add_row(KIND_POLL, 7'd12, 7'd0, 7'd0, 32'h0000_0FA0, 1'b0, '0);
        add_row(KIND_POLL, 7'd12, 7'd0, 7'd0, 32'h1000_0FA0, 1'b0, '0);
        add_row(KIND_POLL, 7'd12, 7'd0, 7'd2, 32'h1000_1388, 1'b0, '0);
        add_row(KIND_START, 7'd5, 7'd30, 7'd30, 32'h5555_5555, 1'b0, '0);
        add_row(KIND_POLL, 7'd5, 7'd30, 7'd30, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(KIND_POLL, 7'd5, 7'd30, 7'd31, 32'hAAAA_AE92, 1'b0, '0);
        add_row(KIND_POLL, 7'd5, 7'd30, 7'd32, 32'hAAAA_B27A, 1'b0, '0);
        add_row(KIND_POLL, 7'd24, 7'd60, 7'd0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(KIND_POLL, 7'd0, 7'd0, 7'd127, 32'h0000_0000, 1'b0, '0);
        add_row(KIND_START, 7'd0, 7'd0, 7'd59, 32'h8000_0000, 1'b0, '0);
        add_row(KIND_POLL, 7'd1, 7'd1, 7'd1, 32'h8000_0001, 1'b0, '0);
        add_row(KIND_POLL, 7'd1, 7'd1, 7'd0, 32'h7FFF_FFFF, 1'b0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 74;
                end
                1: begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 36;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_gain(gain_set[p]);
            phase_no = p;
            sat_probe();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == 120) drain_results();
                next_random_item(it);
                send_item(it, 1'b0, '0);
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (err_cnt == 0 && exp_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
